@@ hdl/lphs_pkg.sv @@
// ---------------------------------------------------------------------------
// lphs_pkg: shared types and constants of the linear-probe hash set
// Default geometry, operation and status codes, and the result record that
// travels from the probe controller to the output register.
// ---------------------------------------------------------------------------
package lphs_pkg;

   // Default geometry
   localparam int LPHS_INDEX_BITS = 4;
   localparam int LPHS_KEY_WIDTH  = 32;

   // Fixed widths of the request and result fields
   localparam int OP_W        = 2;
   localparam int SLOT_W      = 4;
   localparam int OCC_W       = 5;
   localparam int RSP_TDATA_W = 16;

   // Operation codes; every other code behaves as a lookup
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_MISSING  = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   typedef struct packed {
      logic                found;
      logic [SLOT_W-1:0]   slot;
      status_type          status;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

@@ hdl/lphs_mem.sv @@
// ---------------------------------------------------------------------------
// lphs_mem: slot table storage
// One write port and one read port, read data registered, with a write-first
// bypass when both ports address the same slot in one cycle.
// ---------------------------------------------------------------------------
module lphs_mem #(
   parameter int INDEX_BITS = lphs_pkg::LPHS_INDEX_BITS,
   parameter int KEY_WIDTH  = lphs_pkg::LPHS_KEY_WIDTH
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [INDEX_BITS-1:0] wr_addr,
   input  logic [KEY_WIDTH-1:0]  wr_data,
   input  logic [INDEX_BITS-1:0] rd_addr,
   output logic [KEY_WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 2 ** INDEX_BITS;

   logic [KEY_WIDTH-1:0] slots_ff [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   // Write the addressed slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   // Read with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lphs_ctrl.sv @@
// ---------------------------------------------------------------------------
// lphs_ctrl: probe and compaction sequencer
// Clears the table after reset, then walks the probe path one slot a cycle,
// places inserted keys, and closes the gap left by a delete by shifting
// later entries back toward their home slots.
// ---------------------------------------------------------------------------
module lphs_ctrl #(
   parameter int INDEX_BITS = lphs_pkg::LPHS_INDEX_BITS,
   parameter int KEY_WIDTH  = lphs_pkg::LPHS_KEY_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lphs_pkg::OP_W-1:0]   req_op,
   input  logic [KEY_WIDTH-1:0]        req_key,
   // table access
   output logic                        wr_en,
   output logic [INDEX_BITS-1:0]       wr_addr,
   output logic [KEY_WIDTH-1:0]        wr_data,
   output logic [INDEX_BITS-1:0]       rd_addr,
   input  logic [KEY_WIDTH-1:0]        rd_data,
   // result handoff
   output logic                        res_valid,
   input  logic                        res_ready,
   output lphs_pkg::rsp_type           res
);

   localparam logic [KEY_WIDTH-1:0]  EMPTY_KEY = '1;
   localparam logic [INDEX_BITS-1:0] IDX_ONE   = INDEX_BITS'(1);
   localparam logic [INDEX_BITS:0]   CNT_ONE   = (INDEX_BITS + 1)'(1);

   typedef enum logic [5:0] {
      ST_CLEAR     = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_PROBE     = 6'b000100,
      ST_SHIFT     = 6'b001000,
      ST_SHIFT_END = 6'b010000,
      ST_DONE      = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [INDEX_BITS-1:0]       clr_ff, clr_in;
   logic [INDEX_BITS:0]         count_ff, count_in;
   logic [lphs_pkg::OP_W-1:0]   op_ff, op_in;
   logic [KEY_WIDTH-1:0]        key_ff, key_in;
   logic [INDEX_BITS-1:0]       pos_ff, pos_in;
   logic [INDEX_BITS-1:0]       hole_ff, hole_in;
   logic [INDEX_BITS-1:0]       step_ff, step_in;
   logic                        found_ff, found_in;
   logic [INDEX_BITS-1:0]       at_ff, at_in;
   lphs_pkg::status_type        status_ff, status_in;

   logic                        hit;
   logic                        empty;
   logic                        last;
   logic [INDEX_BITS-1:0]       home;
   logic                        stays;
   logic [INDEX_BITS+lphs_pkg::SLOT_W-1:0] slot_ext;
   logic [INDEX_BITS+lphs_pkg::OCC_W:0]    occ_ext;

   // Classify the slot just read
   assign hit   = (rd_data == key_ff);
   assign empty = (rd_data == EMPTY_KEY);
   assign last  = &step_ff;
   assign home  = rd_data[INDEX_BITS-1:0];

   // An entry may stay when its home lies cyclically in (hole, j]
   always_comb begin
      if (hole_ff <= pos_ff) begin
         stays = (hole_ff < home) && (home <= pos_ff);
      end else begin
         stays = (hole_ff < home) || (home <= pos_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_addr   = (state_ff == ST_IDLE) ? req_key[INDEX_BITS-1:0] : pos_ff + IDX_ONE;

   // Sequence one item
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      hole_in   = hole_ff;
      step_in   = step_ff;
      found_in  = found_ff;
      at_in     = at_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = EMPTY_KEY;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_ONE;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               key_in    = req_key;
               pos_in    = req_key[INDEX_BITS-1:0];
               step_in   = '0;
               found_in  = 1'b0;
               at_in     = '0;
               status_in = lphs_pkg::STATUS_OK;
               if (req_key == EMPTY_KEY) begin
                  status_in = lphs_pkg::STATUS_RESERVED;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (op_ff == lphs_pkg::OP_INSERT) begin
               // place in the first empty slot, note any copy on the way
               if (empty) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff;
                  wr_data  = key_ff;
                  count_in = count_ff + CNT_ONE;
                  at_in    = pos_ff;
                  state_in = ST_DONE;
               end else begin
                  found_in = found_ff | hit;
                  if (last) begin
                     status_in = lphs_pkg::STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     pos_in  = pos_ff + IDX_ONE;
                     step_in = step_ff + IDX_ONE;
                  end
               end
            end else if (hit) begin
               found_in = 1'b1;
               at_in    = pos_ff;
               if (op_ff == lphs_pkg::OP_DELETE) begin
                  // open the hole and start compaction at the next slot
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff;
                  count_in = count_ff - CNT_ONE;
                  hole_in  = pos_ff;
                  pos_in   = pos_ff + IDX_ONE;
                  step_in  = '0;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (empty || last) begin
               status_in = lphs_pkg::STATUS_MISSING;
               state_in  = ST_DONE;
            end else begin
               pos_in  = pos_ff + IDX_ONE;
               step_in = step_ff + IDX_ONE;
            end
         end
         ST_SHIFT: begin
            if (empty) begin
               wr_en    = 1'b1;
               wr_addr  = hole_ff;
               state_in = ST_DONE;
            end else begin
               // pull the entry back; its old place becomes the hole
               if (!stays) begin
                  wr_en   = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = rd_data;
                  hole_in = pos_ff;
               end
               if (last) begin
                  state_in = ST_SHIFT_END;
               end else begin
                  pos_in  = pos_ff + IDX_ONE;
                  step_in = step_ff + IDX_ONE;
               end
            end
         end
         ST_SHIFT_END: begin
            wr_en    = 1'b1;
            wr_addr  = hole_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      hole_ff   <= hole_in;
      step_ff   <= step_in;
      found_ff  <= found_in;
      at_ff     <= at_in;
      status_ff <= status_in;
   end

   // Fit slot and occupancy to their field widths
   assign slot_ext = {{lphs_pkg::SLOT_W{1'b0}}, at_ff};
   assign occ_ext  = {{lphs_pkg::OCC_W{1'b0}}, count_ff};

   assign res_valid     = (state_ff == ST_DONE);
   assign res.found     = found_ff;
   assign res.slot      = slot_ext[lphs_pkg::SLOT_W-1:0];
   assign res.status    = status_ff;
   assign res.occupancy = occ_ext[lphs_pkg::OCC_W-1:0];

endmodule

@@ hdl/linear_probe_hash_set_top.sv @@
// Open-addressed hash set of keys in a table of 2^INDEX_BITS slots, with
// linear probing from the home slot (the key's low bits) and backward-shift
// deletion, so no tombstones are left. Insert stores the key in the first
// empty slot without a duplicate check and reports full when no slot is
// free; lookup and delete stop at a match, an empty slot or a full circuit.
// The all-ones key marks an empty slot and is answered with the reserved
// status. After reset the block sweeps the table to empty, one slot a
// cycle, and takes no item until the sweep is done. The slots sit in one
// memory with a single read port, so an item is accepted, then probes one
// slot after another, for a delete then walks the compaction slots in turn
// and empties the last hole, and then hands its result to the output
// register; a reserved key skips the probe.
// A new item is taken while the previous result waits in the output register.
// ---------------------------------------------------------------------------
// linear_probe_hash_set_top: hash set with streaming request and result
// Request decode, slot memory, probe sequencer and the output register.
// ---------------------------------------------------------------------------
module linear_probe_hash_set_top #(
   parameter int INDEX_BITS = lphs_pkg::LPHS_INDEX_BITS,
   parameter int KEY_WIDTH  = lphs_pkg::LPHS_KEY_WIDTH,
   localparam int REQ_TDATA_W = ((lphs_pkg::OP_W + KEY_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // op [1:0], key [KEY_WIDTH+1:2], zero padding above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_TDATA_W-1:0]             req_tdata,
   // found [0], slot [4:1], status [6:5], occupancy [11:7], zero padding above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lphs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [lphs_pkg::OP_W-1:0] req_op;
   logic [KEY_WIDTH-1:0]      req_key;
   logic                      wr_en;
   logic [INDEX_BITS-1:0]     wr_addr;
   logic [KEY_WIDTH-1:0]      wr_data;
   logic [INDEX_BITS-1:0]     rd_addr;
   logic [KEY_WIDTH-1:0]      rd_data;
   logic                      res_valid;
   logic                      res_ready;
   lphs_pkg::rsp_type         res;
   logic                      out_valid_ff, out_valid_in;
   lphs_pkg::rsp_type         out_ff;

   // Unpack the request item
   assign req_op  = req_tdata[lphs_pkg::OP_W-1:0];
   assign req_key = req_tdata[KEY_WIDTH+lphs_pkg::OP_W-1:lphs_pkg::OP_W];

   lphs_mem #(
      .INDEX_BITS (INDEX_BITS),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lphs_ctrl #(
      .INDEX_BITS (INDEX_BITS),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_op),
      .req_key   (req_key),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Load the output register when it is empty or being drained
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   // Pack the result item
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.occupancy, out_ff.status, out_ff.slot, out_ff.found};

   // A finished result always lands in the output register next cycle
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_tvalid)
      else $error("result handed off but output register not loaded");

   // The sequencer never takes an item while it holds a result
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && res_valid))
      else $error("item accepted while a result is pending");

   // Any status other than ok reports slot zero
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_ff.status != lphs_pkg::STATUS_OK) |-> (out_ff.slot == '0))
      else $error("non-ok result carries a slot");

   // A reserved key is never reported as present
   a_reserved: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.status == lphs_pkg::STATUS_RESERVED) |-> !res.found)
      else $error("reserved key reported as found");

endmodule

@@ test/linear_probe_hash_set_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_probe_hash_set_top_tb: self-checking bench for the hash set
// Drives insert, lookup and delete items over the request stream. A local
// model of the slot table predicts each result, and every returned item is
// checked field by field. Random idle and stall bursts, and one long result
// hold-off, are applied along the way.
// ---------------------------------------------------------------------------
module linear_probe_hash_set_top_tb;

   localparam int KEY_W       = lphs_pkg::LPHS_KEY_WIDTH;
   localparam int TABLE_SLOTS = 1 << lphs_pkg::LPHS_INDEX_BITS;
   localparam int REQ_TDATA_W = ((lphs_pkg::OP_W + KEY_W + 7) / 8) * 8;
   localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

   // Codes the package leaves unnamed: lookup and the spare code
   localparam logic [lphs_pkg::OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [lphs_pkg::OP_W-1:0] OP_SPARE  = 2'd3;

   localparam int RANDOM_ITEMS     = 1400;
   localparam int QUIET_TAIL_ITEMS = 200;
   localparam int DRAIN_PAUSE_AT   = 600;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;

   typedef struct packed {
      logic [lphs_pkg::OP_W-1:0] op;
      logic [KEY_W-1:0]          key;
      logic [4:0]                reps;
      logic                      typed;
      lphs_pkg::rsp_type         rsp;
   } stim_row;

   typedef struct packed {
      logic              typed;
      lphs_pkg::rsp_type rsp;
   } typed_outcome;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [REQ_TDATA_W-1:0]           req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lphs_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // Local copy of the slot table
   logic [KEY_W-1:0]          set_slots [TABLE_SLOTS];
   logic [lphs_pkg::OCC_W-1:0] set_count;

   lphs_pkg::rsp_type expected_rsp_q [$];
   typed_outcome      typed_outcome_q [$];
   stim_row           directed_rows [$];

   int mismatch_count = 0;
   int requests_taken = 0;
   int hold_left      = 0;
   bit long_hold_done = 1'b0;
   int recv_cycle     = 0;
   bit quiet_tail     = 1'b0;

   linear_probe_hash_set_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // op [1:0], key [33:2], zero padding above
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // found [0], slot [4:1], status [6:5], occupancy [11:7]
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Apply one operation to the local table and return the result item
   function automatic lphs_pkg::rsp_type hash_set_apply(
         input logic [lphs_pkg::OP_W-1:0] op,
         input logic [KEY_W-1:0]          key);
      lphs_pkg::rsp_type r;
      int      p;
      int      n;
      int      hit_at;
      int      hole;
      int      j;
      int      home;
      bit      hit;
      bit      stays;
      bit      placed;
      r        = '0;
      r.status = lphs_pkg::STATUS_OK;
      if (key == EMPTY_KEY) begin
         r.status = lphs_pkg::STATUS_RESERVED;
      end else begin
         // probe for the first match, stop at an empty slot or a full circuit
         hit    = 1'b0;
         hit_at = 0;
         p      = key & (TABLE_SLOTS - 1);
         for (n = 0; n < TABLE_SLOTS; n++) begin
            if (set_slots[p] == key) begin
               hit    = 1'b1;
               hit_at = p;
               break;
            end
            if (set_slots[p] == EMPTY_KEY) break;
            p = (p + 1) % TABLE_SLOTS;
         end
         r.found = hit;
         if (op == lphs_pkg::OP_INSERT) begin
            placed = 1'b0;
            if (set_count < TABLE_SLOTS) begin
               p = key & (TABLE_SLOTS - 1);
               for (n = 0; n < TABLE_SLOTS; n++) begin
                  if (set_slots[p] == EMPTY_KEY) begin
                     set_slots[p] = key;
                     set_count    = set_count + 1'b1;
                     r.slot       = p[lphs_pkg::SLOT_W-1:0];
                     placed       = 1'b1;
                     break;
                  end
                  p = (p + 1) % TABLE_SLOTS;
               end
            end
            if (!placed) r.status = lphs_pkg::STATUS_FULL;
         end else if (op == lphs_pkg::OP_DELETE) begin
            if (hit) begin
               r.slot = hit_at[lphs_pkg::SLOT_W-1:0];
               // close the gap: pull back entries whose home lies outside (hole, j]
               hole = hit_at;
               j    = hit_at;
               set_slots[hole] = EMPTY_KEY;
               for (n = 0; n < TABLE_SLOTS; n++) begin
                  j = (j + 1) % TABLE_SLOTS;
                  if (set_slots[j] == EMPTY_KEY) break;
                  home = set_slots[j] & (TABLE_SLOTS - 1);
                  if (hole <= j) stays = (hole < home) && (home <= j);
                  else           stays = (hole < home) || (home <= j);
                  if (!stays) begin
                     set_slots[hole] = set_slots[j];
                     set_slots[j]    = EMPTY_KEY;
                     hole            = j;
                  end
               end
               if (set_count > 0) set_count = set_count - 1'b1;
            end else begin
               r.status = lphs_pkg::STATUS_MISSING;
            end
         end else begin
            if (hit) r.slot = hit_at[lphs_pkg::SLOT_W-1:0];
            else     r.status = lphs_pkg::STATUS_MISSING;
         end
      end
      r.occupancy = set_count;
      return r;
   endfunction

   task automatic add_row(input logic [lphs_pkg::OP_W-1:0] op,
                          input logic [KEY_W-1:0] key,
                          input int reps, input bit typed, input logic found,
                          input int slot, input lphs_pkg::status_type status,
                          input int occ);
      stim_row row;
      row.op            = op;
      row.key           = key;
      row.reps          = reps[4:0];
      row.typed         = typed;
      row.rsp.found     = found;
      row.rsp.slot      = slot[lphs_pkg::SLOT_W-1:0];
      row.rsp.status    = status;
      row.rsp.occupancy = occ[lphs_pkg::OCC_W-1:0];
      directed_rows.push_back(row);
   endtask

   // Present one item and hold it until the block takes it
   task automatic offer_item(input logic [lphs_pkg::OP_W-1:0] op,
                             input logic [KEY_W-1:0] key,
                             input bit typed, input lphs_pkg::rsp_type typed_rsp);
      typed_outcome h;
      h.typed = typed;
      h.rsp   = typed_rsp;
      typed_outcome_q.push_back(h);
      req_tdata  <= {{(REQ_TDATA_W - lphs_pkg::OP_W - KEY_W){1'b0}}, key, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Result side: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      recv_cycle <= recv_cycle + 1;
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && requests_taken >= LONG_HOLD_AT) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD_CYCLES - 1;
         rsp_tready     <= 1'b0;
      end else if (!quiet_tail && (recv_cycle % 600) >= 200 &&
                   $urandom_range(0, 5) == 0) begin
         hold_left  <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check returned items, then predict for newly taken ones
   always @(posedge clock) begin
      lphs_pkg::rsp_type want;
      typed_outcome      h;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("result item with nothing expected, tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tdata[0] !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[4:1] !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[4:1]);
                  mismatch_count++;
               end
               if (rsp_tdata[6:5] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[6:5]);
                  mismatch_count++;
               end
               if (rsp_tdata[11:7] !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d", want.occupancy,
                         rsp_tdata[11:7]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = hash_set_apply(req_tdata[lphs_pkg::OP_W-1:0],
                                  req_tdata[lphs_pkg::OP_W+KEY_W-1:lphs_pkg::OP_W]);
            h    = typed_outcome_q.pop_front();
            if (h.typed) want = h.rsp;
            expected_rsp_q.push_back(want);
            requests_taken <= requests_taken + 1;
         end
      end
   end

   initial begin
      stim_row                   row;
      lphs_pkg::rsp_type         none;
      logic [KEY_W-1:0]          key_pool [32];
      logic [KEY_W-1:0]          key;
      logic [KEY_W-1:0]          raw;
      logic [lphs_pkg::OP_W-1:0] op;
      int               i;
      int               n;
      int               roll;
      int               phase;
      int               insert_pct;
      int               delete_pct;
      int               pool_n;
      int               pool_wr;
      int               cluster_base;

      none    = '0;
      pool_n  = 0;
      pool_wr = 0;
      for (i = 0; i < TABLE_SLOTS; i++) set_slots[i] = EMPTY_KEY;
      set_count = '0;

      // Directed rows: typed results where they are obvious, else predicted
      add_row(OP_LOOKUP, 32'h0000_0005, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_MISSING, 0);
      add_row(lphs_pkg::OP_DELETE, 32'h0000_0005, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_MISSING, 0);
      add_row(lphs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_RESERVED, 0);
      add_row(OP_SPARE, 32'hFFFF_FFFF, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_RESERVED, 0);
      add_row(lphs_pkg::OP_INSERT, 32'h0000_0000, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_OK, 1);
      add_row(lphs_pkg::OP_INSERT, 32'hFFFF_FFFE, 1, 1'b1, 1'b0, 14,
              lphs_pkg::STATUS_OK, 2);
      // collision, duplicate insert, spare code on a present key
      add_row(lphs_pkg::OP_INSERT, 32'h0000_0010, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(lphs_pkg::OP_INSERT, 32'h0000_0010, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(OP_SPARE, 32'h0000_0010, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      // probe wraps past the last slot, then a delete shifts across the wrap
      add_row(lphs_pkg::OP_INSERT, 32'h0000_001F, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(lphs_pkg::OP_INSERT, 32'h0000_002F, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(lphs_pkg::OP_DELETE, 32'h0000_0000, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(OP_LOOKUP, 32'h0000_002F, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      // fill the table, then hit it full and probe a full circuit
      add_row(lphs_pkg::OP_INSERT, 32'h3C00_0003, 11, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);
      add_row(lphs_pkg::OP_INSERT, 32'h1234_5678, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_FULL, 16);
      add_row(OP_LOOKUP, 32'h0BAD_CAFE, 1, 1'b1, 1'b0, 0,
              lphs_pkg::STATUS_MISSING, 16);
      add_row(lphs_pkg::OP_DELETE, 32'h0000_0010, 1, 1'b0, 1'b0, 0,
              lphs_pkg::STATUS_OK, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (n = 0; n < row.reps; n++) begin
            offer_item(row.op, row.key + n * 32'h0100_0005, row.typed, row.rsp);
         end
      end

      // Random part: phases lean toward filling, mixing and draining
      cluster_base = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         phase = (i / 120) % 4;
         if (i % 120 == 0) cluster_base = $urandom_range(0, TABLE_SLOTS - 1);
         if (i == RANDOM_ITEMS - QUIET_TAIL_ITEMS) quiet_tail <= 1'b1;

         // pause the sender once until every result is back
         if (i == DRAIN_PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_rsp_q.size() != 0);
         end else if (i < RANDOM_ITEMS - QUIET_TAIL_ITEMS && (i % 90) >= 30 &&
                      $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end

         insert_pct = (phase == 0) ? 60 : (phase == 2) ? 15 : 35;
         delete_pct = (phase == 2) ? 55 : 25;
         roll = $urandom_range(0, 99);
         if (roll < insert_pct)                   op = lphs_pkg::OP_INSERT;
         else if (roll < insert_pct + delete_pct) op = lphs_pkg::OP_DELETE;
         else if (roll < 95)                      op = OP_LOOKUP;
         else                                     op = OP_SPARE;

         // pick a reserved, recent, clustered or fully random key
         raw  = $urandom();
         roll = $urandom_range(0, 99);
         if (roll < 3)                      key = EMPTY_KEY;
         else if (roll < 45 && pool_n > 0)  key = key_pool[$urandom_range(0, pool_n - 1)];
         else if (roll < 75)
            key = {raw[KEY_W-1:4], 4'((cluster_base + $urandom_range(0, 2)) % TABLE_SLOTS)};
         else                               key = raw;

         if (op == lphs_pkg::OP_INSERT && key != EMPTY_KEY) begin
            key_pool[pool_wr] = key;
            pool_wr = (pool_wr + 1) % 32;
            if (pool_n < 32) pool_n++;
         end
         offer_item(op, key, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      // Wait out every pending result, then the block's latency
      do @(posedge clock); while (expected_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
